// ===== rtl/afr_pkg.sv =====
package afr_pkg;

	// Sizing
	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int LEN_W           = 6;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	// Framing bytes and special addresses
	localparam logic [7:0] SYNC1_BYTE  = 8'hFD;
	localparam logic [7:0] SYNC2_BYTE  = 8'h7E;
	localparam logic [7:0] ETX1_BYTE   = 8'hFC;
	localparam logic [7:0] ETX2_BYTE   = 8'h0D;
	localparam logic [7:0] BCAST_ADDR  = 8'hFE;
	localparam logic [7:0] MASTER_ADDR = 8'h01;
	localparam logic [7:0] CMD_ACK     = 8'h00;

	// Input opcodes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_SENT = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_MASTER = 2'd2;

	localparam logic [15:0] TIMEOUT_RST = 16'd50;
	localparam logic [15:0] TICKS_MAX   = 16'hFFFF;

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_SENDER,
		PH_DEST,
		PH_CMD,
		PH_INDEX,
		PH_LEN,
		PH_PAYLOAD,
		PH_CSUM,
		PH_ETX1,
		PH_ETX2
	} phase_t;

	typedef enum logic [1:0] {
		DISP_ACK,
		DISP_LOCAL,
		DISP_OTHER,
		DISP_IGNORED
	} disp_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_PUT
	} back_state_t;

	typedef struct packed {
		logic [7:0]  own_addr;
		logic [15:0] timeout_ticks;
		logic        accept_master;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       sender;
		logic [7:0]       dest;
		logic [7:0]       command;
		logic [7:0]       index;
		logic [LEN_W-1:0] length;
		disp_t            disp;
		logic             fwd;
		logic             reply;
	} frame_t;

	typedef struct packed {
		logic             en;
		logic [LEN_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

	typedef struct packed {
		logic busy;
		logic full;
	} back_stat_t;

endpackage

// ===== rtl/afr_ifs.sv =====
interface afr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] rx_byte;
	logic [7:0] sent_dest_addr;
	logic [7:0] sent_index;

	modport source (output valid, opcode, rx_byte, sent_dest_addr, sent_index, input ready);
	modport sink (input valid, opcode, rx_byte, sent_dest_addr, sent_index, output ready);
endinterface

interface afr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] sender_addr;
	logic [7:0] dest_addr;
	logic [7:0] command;
	logic [7:0] seq_index;
	logic [5:0] payload_length;
	logic [7:0] payload_byte;
	logic       last;
	logic [1:0] disposition;
	logic       forward_copy;
	logic       send_ack_reply;

	modport source (output valid, sender_addr, dest_addr, command, seq_index, payload_length,
		payload_byte, last, disposition, forward_copy, send_ack_reply, input ready);
	modport sink (input valid, sender_addr, dest_addr, command, seq_index, payload_length,
		payload_byte, last, disposition, forward_copy, send_ack_reply, output ready);
endinterface

interface afr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/addressed_frame_receiver.sv =====
// Once a frame's closing byte beat is accepted, its header is queued; the back end then pops it and
// reads the store for each result beat in turn. One input beat is taken per cycle unless a stall holds it.
// A payload byte beat waits while a previous frame is still queued or being read out of the payload store.
// A closing byte beat waits while the two-entry frame queue is full.
// Reset (arst_n low, asynchronous) returns the parser to sync hunting, empties the queue,
// and loads the registers with own address 0, timeout 50 ticks and master frames excluded.
module addressed_frame_receiver #(
	parameter int MAX_PAYLOAD = afr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	afr_in_if.sink     rx_in,
	afr_out_if.source  res_out,
	afr_cfg_if.sink    cfg
);

	afr_pkg::cfg_t       cfg_q;
	afr_pkg::back_stat_t stat;
	afr_pkg::frame_t     push_frame;
	afr_pkg::frame_t     q_frame;
	afr_pkg::wr_t        wr;
	logic                push;
	logic                pop;
	logic                q_empty;
	logic                q_full;
	logic                back_idle;

	// Configuration writes are registered; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_addr      <= 8'd0;
			cfg_q.timeout_ticks <= afr_pkg::TIMEOUT_RST;
			cfg_q.accept_master <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				afr_pkg::REG_OWN_ADDR:      cfg_q.own_addr      <= cfg.data[7:0];
				afr_pkg::REG_TIMEOUT:       cfg_q.timeout_ticks <= cfg.data;
				afr_pkg::REG_ACCEPT_MASTER: cfg_q.accept_master <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// The back end counts as busy while any frame is queued or being read out;
	// the parser must not overwrite the payload store during that time.
	assign stat.busy = !q_empty || !back_idle;
	assign stat.full = q_full;

	// Front: parse the byte stream, track idle ticks, classify finished frames.
	afr_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.rx_in      (rx_in),
		.stat       (stat),
		.push       (push),
		.push_frame (push_frame),
		.wr         (wr)
	);

	// Queue of classified frame headers between the two halves.
	afr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (q_frame),
		.empty      (q_empty),
		.full       (q_full)
	);

	// Back: hold the payload store and emit one result beat per payload byte, or a single beat for an empty frame.
	afr_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_empty (q_empty),
		.q_frame (q_frame),
		.pop     (pop),
		.idle    (back_idle),
		.res_out (res_out)
	);

endmodule

// ===== rtl/afr_front.sv =====
module afr_front #(
	parameter int MAX_PAYLOAD = afr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  afr_pkg::cfg_t      cfg,
	afr_in_if.sink             rx_in,
	input  afr_pkg::back_stat_t stat,
	output logic               push,
	output afr_pkg::frame_t    push_frame,
	output afr_pkg::wr_t       wr
);

	localparam int LW = afr_pkg::LEN_W;

	afr_pkg::phase_t phase_q, phase_d;
	logic [7:0]    sum_q, sum_d;
	logic [7:0]    sender_q, sender_d;
	logic [7:0]    dest_q, dest_d;
	logic [7:0]    cmd_q, cmd_d;
	logic [7:0]    index_q, index_d;
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] count_q, count_d;
	logic [15:0]   idle_q, idle_d;
	logic [7:0]    await_dest_q, await_dest_d;
	logic [7:0]    await_index_q, await_index_d;
	logic          accept;
	logic          stall;
	logic          allowed;
	logic          for_us;
	logic [7:0]    b;

	assign b = rx_in.rx_byte;

	// Hold a payload beat while the back end still reads the store, and a
	// closing beat while the queue has no room.
	assign stall = (rx_in.opcode == afr_pkg::OP_BYTE) &&
		((phase_q == afr_pkg::PH_PAYLOAD && stat.busy) ||
		 (phase_q == afr_pkg::PH_ETX2 && stat.full));
	assign rx_in.ready = !stall;
	assign accept = rx_in.valid && !stall;

	// Classify the finished frame from the header registers.
	assign allowed = cfg.accept_master || (sender_q != afr_pkg::MASTER_ADDR);
	assign for_us  = (dest_q == cfg.own_addr) || (dest_q == afr_pkg::BCAST_ADDR);

	always_comb begin
		push_frame.sender  = sender_q;
		push_frame.dest    = dest_q;
		push_frame.command = cmd_q;
		push_frame.index   = index_q;
		push_frame.length  = len_q;
		push_frame.fwd     = (dest_q != cfg.own_addr);
		push_frame.reply   = 1'b0;
		if (cmd_q == afr_pkg::CMD_ACK) begin
			if (sender_q == await_dest_q && dest_q == cfg.own_addr &&
			    index_q == await_index_q) begin
				push_frame.disp = afr_pkg::DISP_ACK;
			end else begin
				push_frame.disp = afr_pkg::DISP_IGNORED;
			end
		end else if (for_us && allowed) begin
			push_frame.disp  = afr_pkg::DISP_LOCAL;
			push_frame.reply = (index_q != 8'd0) && (dest_q != afr_pkg::BCAST_ADDR);
		end else if (allowed) begin
			push_frame.disp = afr_pkg::DISP_OTHER;
		end else begin
			push_frame.disp = afr_pkg::DISP_IGNORED;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		sum_d         = sum_q;
		sender_d      = sender_q;
		dest_d        = dest_q;
		cmd_d         = cmd_q;
		index_d       = index_q;
		len_d         = len_q;
		count_d       = count_q;
		idle_d        = idle_q;
		await_dest_d  = await_dest_q;
		await_index_d = await_index_q;
		push          = 1'b0;
		wr.en         = 1'b0;
		wr.addr       = count_q;
		wr.data       = b;
		if (accept) begin
			case (rx_in.opcode)
				afr_pkg::OP_SENT: begin
					await_dest_d  = rx_in.sent_dest_addr;
					await_index_d = rx_in.sent_index;
				end
				afr_pkg::OP_TICK: begin
					if (idle_q != afr_pkg::TICKS_MAX) idle_d = idle_q + 16'd1;
				end
				afr_pkg::OP_BYTE: begin
					case (phase_q)
						afr_pkg::PH_SYNC2: begin
							if (b == afr_pkg::SYNC2_BYTE) begin
								phase_d  = afr_pkg::PH_SENDER;
								sum_d    = 8'd0;
								sender_d = 8'd0;
								dest_d   = 8'd0;
								cmd_d    = 8'd0;
								index_d  = 8'd0;
								len_d    = '0;
								count_d  = '0;
							end else begin
								phase_d = afr_pkg::PH_HUNT;
							end
						end
						afr_pkg::PH_SENDER: begin
							sender_d = b;
							sum_d    = sum_q + b;
							phase_d  = afr_pkg::PH_DEST;
						end
						afr_pkg::PH_DEST: begin
							dest_d  = b;
							sum_d   = sum_q + b;
							phase_d = afr_pkg::PH_CMD;
						end
						afr_pkg::PH_CMD: begin
							cmd_d   = b;
							sum_d   = sum_q + b;
							phase_d = afr_pkg::PH_INDEX;
						end
						afr_pkg::PH_INDEX: begin
							index_d = b;
							sum_d   = sum_q + b;
							phase_d = afr_pkg::PH_LEN;
						end
						afr_pkg::PH_LEN: begin
							sum_d = sum_q + b;
							if (b >= 8'(MAX_PAYLOAD)) begin
								phase_d = afr_pkg::PH_HUNT;
							end else begin
								len_d   = b[LW-1:0];
								phase_d = (b == 8'd0) ? afr_pkg::PH_CSUM : afr_pkg::PH_PAYLOAD;
							end
						end
						afr_pkg::PH_PAYLOAD: begin
							wr.en   = 1'b1;
							sum_d   = sum_q + b;
							count_d = count_q + LW'(1);
							if (count_d >= len_q) phase_d = afr_pkg::PH_CSUM;
						end
						afr_pkg::PH_CSUM: begin
							phase_d = (sum_q == b) ? afr_pkg::PH_ETX1 : afr_pkg::PH_HUNT;
						end
						afr_pkg::PH_ETX1: begin
							phase_d = (b == afr_pkg::ETX1_BYTE) ? afr_pkg::PH_ETX2 :
								afr_pkg::PH_HUNT;
						end
						afr_pkg::PH_ETX2: begin
							phase_d = afr_pkg::PH_HUNT;
							push    = (b == afr_pkg::ETX2_BYTE);
						end
						default: begin
							if (b == afr_pkg::SYNC1_BYTE) begin
								phase_d = afr_pkg::PH_SYNC2;
								idle_d  = 16'd0;
							end else begin
								phase_d = afr_pkg::PH_HUNT;
							end
						end
					endcase
				end
				default: begin
				end
			endcase
			// Abandon a partial frame once the line has been idle too long.
			if ((rx_in.opcode == afr_pkg::OP_BYTE || rx_in.opcode == afr_pkg::OP_TICK) &&
			    idle_d > cfg.timeout_ticks && phase_d != afr_pkg::PH_HUNT) begin
				phase_d = afr_pkg::PH_HUNT;
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= afr_pkg::PH_HUNT;
			sum_q         <= 8'd0;
			sender_q      <= 8'd0;
			dest_q        <= 8'd0;
			cmd_q         <= 8'd0;
			index_q       <= 8'd0;
			len_q         <= '0;
			count_q       <= '0;
			idle_q        <= 16'd0;
			await_dest_q  <= 8'd0;
			await_index_q <= 8'd0;
		end else begin
			phase_q       <= phase_d;
			sum_q         <= sum_d;
			sender_q      <= sender_d;
			dest_q        <= dest_d;
			cmd_q         <= cmd_d;
			index_q       <= index_d;
			len_q         <= len_d;
			count_q       <= count_d;
			idle_q        <= idle_d;
			await_dest_q  <= await_dest_d;
			await_index_q <= await_index_d;
		end
	end

endmodule

// ===== rtl/afr_queue.sv =====
module afr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  afr_pkg::frame_t push_frame,
	input  logic            pop,
	output afr_pkg::frame_t pop_frame,
	output logic            empty,
	output logic            full
);

	localparam int PW = afr_pkg::QUEUE_PTR_W;
	localparam int CW = afr_pkg::QUEUE_CNT_W;

	afr_pkg::frame_t entry_q [afr_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign empty     = (cnt_q == CW'(0));
	assign full      = (cnt_q == CW'(afr_pkg::QUEUE_DEPTH));
	assign pop_frame = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(afr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(afr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ===== rtl/afr_back.sv =====
module afr_back #(
	parameter int MAX_PAYLOAD = afr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  afr_pkg::wr_t    wr,
	input  logic            q_empty,
	input  afr_pkg::frame_t q_frame,
	output logic            pop,
	output logic            idle,
	afr_out_if.source       res_out
);

	localparam int AW = $clog2(MAX_PAYLOAD);
	localparam int LW = afr_pkg::LEN_W;

	logic [7:0] store [MAX_PAYLOAD];
	logic [7:0] rd_data_q;

	afr_pkg::back_state_t state_q, state_d;
	afr_pkg::frame_t cur_q, cur_d;
	logic [LW-1:0] k_q, k_d;
	logic          last_k;
	logic          load;
	logic          out_valid_q;
	afr_pkg::frame_t out_frame_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	// Payload store: written by the parser, read one entry per result.
	always_ff @(posedge clk) begin
		if (wr.en) store[wr.addr[AW-1:0]] <= wr.data;
		rd_data_q <= store[k_q[AW-1:0]];
	end

	assign last_k = (cur_q.length == '0) || (k_q == cur_q.length - LW'(1));
	assign idle   = (state_q == afr_pkg::BK_IDLE);

	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		k_d     = k_q;
		pop     = 1'b0;
		load    = 1'b0;
		case (state_q)
			afr_pkg::BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					cur_d   = q_frame;
					k_d     = '0;
					state_d = afr_pkg::BK_FETCH;
				end
			end
			afr_pkg::BK_FETCH: begin
				state_d = afr_pkg::BK_PUT;
			end
			afr_pkg::BK_PUT: begin
				if (!out_valid_q || res_out.ready) begin
					load = 1'b1;
					if (last_k) begin
						state_d = afr_pkg::BK_IDLE;
					end else begin
						k_d     = k_q + LW'(1);
						state_d = afr_pkg::BK_FETCH;
					end
				end
			end
			default: begin
				state_d = afr_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= afr_pkg::BK_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (load) out_valid_q <= 1'b1;
			else if (res_out.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (load) begin
			out_frame_q <= cur_q;
			out_byte_q  <= (cur_q.length == '0) ? 8'd0 : rd_data_q;
			out_last_q  <= last_k;
		end
	end

	assign res_out.valid          = out_valid_q;
	assign res_out.sender_addr    = out_frame_q.sender;
	assign res_out.dest_addr      = out_frame_q.dest;
	assign res_out.command        = out_frame_q.command;
	assign res_out.seq_index      = out_frame_q.index;
	assign res_out.payload_length = out_frame_q.length;
	assign res_out.payload_byte   = out_byte_q;
	assign res_out.last           = out_last_q;
	assign res_out.disposition    = out_frame_q.disp;
	assign res_out.forward_copy   = out_frame_q.fwd;
	assign res_out.send_ack_reply = out_frame_q.reply;

endmodule

// ===== rtl/afr_checker.sv =====
module afr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] opcode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] sender_addr,
	input logic [7:0] dest_addr,
	input logic [7:0] command,
	input logic [7:0] seq_index,
	input logic [5:0] payload_length,
	input logic [7:0] payload_byte,
	input logic       last,
	input logic [1:0] disposition,
	input logic       forward_copy,
	input logic       send_ack_reply
);

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({sender_addr, dest_addr, command, seq_index, payload_length,
			payload_byte, last, disposition, forward_copy, send_ack_reply}))
		else $error("result beat changed while stalled");

	// An empty frame yields exactly one beat with a zero payload byte.
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_length == 6'd0 |-> last && payload_byte == 8'd0)
		else $error("empty frame beat malformed");

	// A reply request only for local, indexed, non-broadcast frames.
	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_ack_reply |-> disposition == afr_pkg::DISP_LOCAL &&
		seq_index != 8'd0 && dest_addr != afr_pkg::BCAST_ADDR)
		else $error("ack reply requested for wrong frame");

	// A matched ack is an ack command addressed to this node, so never forwarded.
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && disposition == afr_pkg::DISP_ACK |-> command == afr_pkg::CMD_ACK &&
		!forward_copy)
		else $error("matched ack inconsistent");

	// Tick and record beats are never held off.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && opcode != afr_pkg::OP_BYTE |-> in_ready)
		else $error("non-byte beat stalled");

endmodule

bind addressed_frame_receiver afr_checker u_afr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (rx_in.valid),
	.in_ready       (rx_in.ready),
	.opcode         (rx_in.opcode),
	.out_valid      (res_out.valid),
	.out_ready      (res_out.ready),
	.sender_addr    (res_out.sender_addr),
	.dest_addr      (res_out.dest_addr),
	.command        (res_out.command),
	.seq_index      (res_out.seq_index),
	.payload_length (res_out.payload_length),
	.payload_byte   (res_out.payload_byte),
	.last           (res_out.last),
	.disposition    (res_out.disposition),
	.forward_copy   (res_out.forward_copy),
	.send_ack_reply (res_out.send_ack_reply)
);
